// ===== rtl/bech32_stream_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// Bech32 stream encoder assertion macros
// Shared helpers for the concurrent checks of the encoder modules.
// ----------------------------------------------------------------------------
`ifndef BECH32_STREAM_ENCODER_DEFINES_SVH
`define BECH32_STREAM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define B32E_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define B32E_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define B32E_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define B32E_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/b32e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bech32 encoder package
// Types, command codes and checksum helpers shared by the encoder modules.
// ----------------------------------------------------------------------------
package b32e_pkg;

	localparam int CSUM_LEN = 6;

	localparam logic [2:0] OUT_NONE      = 3'd0;
	localparam logic [2:0] OUT_ECHO      = 3'd1;
	localparam logic [2:0] OUT_SEP       = 3'd2;
	localparam logic [2:0] OUT_SYM       = 3'd3;
	localparam logic [2:0] OUT_PAD       = 3'd4;
	localparam logic [2:0] OUT_CSUM      = 3'd5;
	localparam logic [2:0] OUT_CSUM_LAST = 3'd6;

	localparam logic [2:0] CHK_NONE  = 3'd0;
	localparam logic [2:0] CHK_ZERO  = 3'd1;
	localparam logic [2:0] CHK_SYM   = 3'd2;
	localparam logic [2:0] CHK_PAD   = 3'd3;
	localparam logic [2:0] CHK_FINAL = 3'd4;
	localparam logic [2:0] CHK_SHIFT = 3'd5;

	localparam logic [7:0] SEP_CHAR = 8'h31;

	localparam logic [29:0] GEN [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

	typedef struct packed {
		logic       accept;
		logic [2:0] out_sel;
		logic [2:0] chk_sel;
		logic       store;
		logic       set_data;
		logic       rd_clear;
		logic       rd_issue;
		logic       rd_lo;
		logic       nb_sub;
		logic       clear_string;
	} b32e_ctl_t;

	typedef struct packed {
		logic out_free;
		logic data_phase;
		logic walk_more;
		logic rd_busy;
		logic more_sym;
		logic need_pad;
	} b32e_stat_t;

	function automatic logic [29:0] pm_step(logic [29:0] chk, logic [4:0] v);
		logic [4:0]  top;
		logic [29:0] r;
		top = chk[29:25];
		r = {chk[24:0], 5'b0} ^ {25'b0, v};
		for (int i = 0; i < 5; i++) begin
			if (top[i]) begin
				r = r ^ GEN[i];
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] sym_char(logic [4:0] s);
		return CHARSET[8 * (31 - int'(s)) +: 8];
	endfunction

endpackage

// ===== rtl/b32e_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bech32 encoder datapath
// HRP store, checksum register, bit regrouping and the output register.
// ----------------------------------------------------------------------------
`include "bech32_stream_encoder_defines.svh"

module b32e_dp #(
	parameter int HRP_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              upper_case_output,
	input  logic              cmd,
	input  logic [7:0]        value,
	input  logic              out_stall,
	input  b32e_pkg::b32e_ctl_t  ctl,
	output b32e_pkg::b32e_stat_t stat,
	output logic              out_valid,
	output logic [7:0]        out_char,
	output logic              out_last,
	output logic              hrp_overflow
);
	import b32e_pkg::*;

	localparam int CNT_W = $clog2(HRP_DEPTH + 1);
	localparam int AW    = (HRP_DEPTH > 1) ? $clog2(HRP_DEPTH) : 1;

	logic [7:0]       mem [HRP_DEPTH];
	logic [7:0]       rd_data_s1;
	logic             rdv_s1;
	logic             rd_lo_s1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             data_phase_q;
	logic             ucase_q;
	logic [29:0]      chk_q;
	logic [11:0]      acc_q;
	logic [3:0]       nb_q;
	logic [7:0]       val_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;
	logic             out_ovf_q;

	logic             full;
	logic             out_free;
	logic [11:0]      sym_wide;
	logic [4:0]       sym;
	logic [8:0]       pad_wide;
	logic [4:0]       pad;
	logic [7:0]       lc;
	logic [4:0]       mem_v;
	logic [7:0]       ch_raw;
	logic [7:0]       ch;
	logic             ovf;

	assign full     = (count_q == CNT_W'(HRP_DEPTH));
	assign out_free = !out_valid_q || !out_stall;
	assign sym_wide = acc_q >> (nb_q - 4'd5);
	assign sym      = sym_wide[4:0];
	assign pad_wide = {acc_q[3:0], 5'b0} >> nb_q;
	assign pad      = pad_wide[4:0];
	assign lc       = to_lower(rd_data_s1);
	assign mem_v    = rd_lo_s1 ? lc[4:0] : {2'b0, lc[7:5]};

	assign stat.out_free   = out_free;
	assign stat.data_phase = data_phase_q;
	assign stat.walk_more  = (ptr_q != count_q);
	assign stat.rd_busy    = rdv_s1;
	assign stat.more_sym   = (nb_q >= 4'd10);
	assign stat.need_pad   = (nb_q != 4'd5);

	always_ff @(posedge clk) begin
		if (ctl.store && !full) begin
			mem[count_q[AW-1:0]] <= val_q;
		end
		if (ctl.rd_issue) begin
			rd_data_s1 <= mem[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1   <= 1'b0;
			rd_lo_s1 <= 1'b0;
		end else begin
			rdv_s1   <= ctl.rd_issue;
			rd_lo_s1 <= ctl.rd_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ucase_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ucase_q <= upper_case_output;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ptr_q        <= '0;
			data_phase_q <= 1'b0;
			nb_q         <= '0;
			chk_q        <= 30'd1;
		end else begin
			if (ctl.clear_string) begin
				count_q <= '0;
			end else if (ctl.store && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctl.rd_clear) begin
				ptr_q <= '0;
			end else if (ctl.rd_issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (ctl.clear_string) begin
				data_phase_q <= 1'b0;
			end else if (ctl.set_data) begin
				data_phase_q <= 1'b1;
			end
			if (ctl.clear_string) begin
				nb_q <= '0;
			end else if (ctl.accept && (cmd || data_phase_q)) begin
				nb_q <= nb_q + 4'd8;
			end else if (ctl.nb_sub) begin
				nb_q <= nb_q - 4'd5;
			end
			if (ctl.clear_string) begin
				chk_q <= 30'd1;
			end else if (rdv_s1) begin
				chk_q <= pm_step(chk_q, mem_v);
			end else begin
				case (ctl.chk_sel)
					CHK_ZERO:  chk_q <= pm_step(chk_q, 5'd0);
					CHK_SYM:   chk_q <= pm_step(chk_q, sym);
					CHK_PAD:   chk_q <= pm_step(chk_q, pad);
					CHK_FINAL: chk_q <= pm_step(chk_q, 5'd0) ^ 30'd1;
					CHK_SHIFT: chk_q <= {chk_q[24:0], 5'b0};
					default:   chk_q <= chk_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			val_q <= value;
			if (cmd || data_phase_q) begin
				acc_q <= {acc_q[3:0], value};
			end
		end
	end

	always_comb begin
		ch_raw = 8'd0;
		ovf    = 1'b0;
		case (ctl.out_sel)
			OUT_ECHO: begin
				ch_raw = full ? 8'd0 : val_q;
				ovf    = full;
			end
			OUT_SEP:       ch_raw = SEP_CHAR;
			OUT_SYM:       ch_raw = sym_char(sym);
			OUT_PAD:       ch_raw = sym_char(pad);
			OUT_CSUM:      ch_raw = sym_char(chk_q[29:25]);
			OUT_CSUM_LAST: ch_raw = sym_char(chk_q[29:25]);
			default:       ch_raw = 8'd0;
		endcase
		ch = ch_raw;
		if (ucase_q && ch_raw >= 8'h61 && ch_raw <= 8'h7a) begin
			ch = ch_raw - 8'd32;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_sel != OUT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_sel != OUT_NONE) begin
			out_char_q <= ch;
			out_last_q <= (ctl.out_sel == OUT_CSUM_LAST);
			out_ovf_q  <= ovf;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign out_last     = out_last_q;
	assign hrp_overflow = out_ovf_q;

	`B32E_ASSERT_IMP(a_out_free, clk, arst_n, ctl.out_sel != OUT_NONE, out_free, "result register overwritten")
	`B32E_ASSERT_IMP(a_rd_bound, clk, arst_n, ctl.rd_issue, ptr_q != count_q, "read beyond stored hrp")
	`B32E_ASSERT_IMP(a_chk_one, clk, arst_n, rdv_s1, ctl.chk_sel == CHK_NONE, "two checksum updates at once")
	`B32E_ASSERT_NXT(a_clear, clk, arst_n, ctl.clear_string, count_q == '0 && !data_phase_q && nb_q == '0, "string state not cleared")

endmodule

// ===== rtl/b32e_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bech32 encoder controller
// Sequences echo, separator, hrp walk, data symbols and checksum output.
// ----------------------------------------------------------------------------
module b32e_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 cmd,
	input  logic                 last,
	input  b32e_pkg::b32e_stat_t stat,
	output logic                 in_stall,
	output b32e_pkg::b32e_ctl_t  ctl
);
	import b32e_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ECHO = 4'd1;
	localparam logic [3:0] S_SEP  = 4'd2;
	localparam logic [3:0] S_WHI  = 4'd3;
	localparam logic [3:0] S_WZ   = 4'd4;
	localparam logic [3:0] S_WLO  = 4'd5;
	localparam logic [3:0] S_WEND = 4'd6;
	localparam logic [3:0] S_SYM  = 4'd7;
	localparam logic [3:0] S_PAD  = 4'd8;
	localparam logic [3:0] S_FZ   = 4'd9;
	localparam logic [3:0] S_FOUT = 4'd10;

	localparam logic [2:0] CNT_END = 3'(CSUM_LEN - 1);

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [2:0] cnt_q;
	logic [2:0] cnt_d;
	logic       hold_last_q;
	logic       hold_data_q;
	logic       is_data;

	assign in_stall = (state_q != S_IDLE);
	assign is_data  = cmd || stat.data_phase;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					if (!is_data) begin
						state_d = S_ECHO;
					end else if (!stat.data_phase) begin
						state_d = S_SEP;
					end else begin
						state_d = S_SYM;
					end
				end
			end
			S_ECHO: begin
				if (stat.out_free) begin
					ctl.out_sel = OUT_ECHO;
					ctl.store   = 1'b1;
					state_d     = hold_last_q ? S_SEP : S_IDLE;
				end
			end
			S_SEP: begin
				if (stat.out_free) begin
					ctl.out_sel  = OUT_SEP;
					ctl.rd_clear = 1'b1;
					ctl.set_data = 1'b1;
					state_d      = S_WHI;
				end
			end
			S_WHI: begin
				if (stat.walk_more) begin
					ctl.rd_issue = 1'b1;
				end else begin
					state_d = S_WZ;
				end
			end
			S_WZ: begin
				if (!stat.rd_busy) begin
					ctl.chk_sel  = CHK_ZERO;
					ctl.rd_clear = 1'b1;
					state_d      = S_WLO;
				end
			end
			S_WLO: begin
				if (stat.walk_more) begin
					ctl.rd_issue = 1'b1;
					ctl.rd_lo    = 1'b1;
				end else begin
					state_d = S_WEND;
				end
			end
			S_WEND: begin
				if (!stat.rd_busy) begin
					cnt_d   = '0;
					state_d = hold_data_q ? S_SYM : S_FZ;
				end
			end
			S_SYM: begin
				if (stat.out_free) begin
					ctl.out_sel = OUT_SYM;
					ctl.chk_sel = CHK_SYM;
					ctl.nb_sub  = 1'b1;
					cnt_d       = '0;
					if (stat.more_sym) begin
						state_d = S_SYM;
					end else if (!hold_last_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = stat.need_pad ? S_PAD : S_FZ;
					end
				end
			end
			S_PAD: begin
				if (stat.out_free) begin
					ctl.out_sel = OUT_PAD;
					ctl.chk_sel = CHK_PAD;
					state_d     = S_FZ;
				end
			end
			S_FZ: begin
				if (cnt_q == CNT_END) begin
					ctl.chk_sel = CHK_FINAL;
					cnt_d       = '0;
					state_d     = S_FOUT;
				end else begin
					ctl.chk_sel = CHK_ZERO;
					cnt_d       = cnt_q + 3'd1;
				end
			end
			S_FOUT: begin
				if (stat.out_free) begin
					ctl.chk_sel = CHK_SHIFT;
					if (cnt_q == CNT_END) begin
						ctl.out_sel      = OUT_CSUM_LAST;
						ctl.clear_string = 1'b1;
						cnt_d            = '0;
						state_d          = S_IDLE;
					end else begin
						ctl.out_sel = OUT_CSUM;
						cnt_d       = cnt_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			hold_last_q <= 1'b0;
			hold_data_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (ctl.accept) begin
				hold_last_q <= last;
				hold_data_q <= is_data;
			end
		end
	end

endmodule

// ===== rtl/bech32_stream_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bech32 stream encoder
// Streaming encoder with checksum constant 1 and optional uppercase output.
// ----------------------------------------------------------------------------
// Input transactions carry cmd, value and last; cmd 0 is an hrp character
// and cmd 1 a data byte. Every output transaction carries one character.
// An hrp character is echoed and stored; once the store is full, a zero is
// echoed with hrp_overflow set. A data byte yields one symbol or two, and the
// controller emits one character per cycle while the receiver does not stall.
// The first data byte of a string, or an hrp character flagged last, also
// emits the separator and walks the stored hrp twice, high bits then low
// bits. The last item adds an optional pad symbol, six checksum steps and six
// checksum characters. Reset returns the block to the hrp phase with an empty
// string and lowercase output. While the receiver stalls, the pending
// character is held and the controller waits before loading the next one; a
// new transaction may still be taken while a finished result waits.
// ----------------------------------------------------------------------------
module bech32_stream_encoder #(
	parameter int HRP_DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       upper_case_output,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       cmd,
	input  logic [7:0] value,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       hrp_overflow
);
	import b32e_pkg::*;

	b32e_ctl_t  ctl;
	b32e_stat_t stat;

	b32e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.last     (last),
		.stat     (stat),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	b32e_dp #(
		.HRP_DEPTH (HRP_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.upper_case_output (upper_case_output),
		.cmd               (cmd),
		.value             (value),
		.out_stall         (out_stall),
		.ctl               (ctl),
		.stat              (stat),
		.out_valid         (out_valid),
		.out_char          (out_char),
		.out_last          (out_last),
		.hrp_overflow      (hrp_overflow)
	);

endmodule
